// File: rtl/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants for the ratio motion scaler with remainder.
// ----------------------------------------------------------------------------
package rms_pkg;

  localparam int CODE_REGS = 4;
  localparam int MAX_CODES = 4;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_STEPS = 32;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [2:0] SLOT_LIMIT = 3'(MAX_CODES < CODE_REGS ? MAX_CODES : CODE_REGS);

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_0      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_1      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_2      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_3      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DENOMINATOR = 3'd7;

  localparam logic [15:0] CODE_X = 16'h0000;
  localparam logic [15:0] CODE_Y = 16'h0001;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic mag;
    logic step;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hit;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage

// File: rtl/rms_ctrl.sv
// ----------------------------------------------------------------------------
// rms_ctrl
// Sequencer: multiply, carry add, magnitude, 32 divide steps, result write.
// ----------------------------------------------------------------------------
module rms_ctrl import rms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_MAG  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    cmd           = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (stat.hit) begin
          cmd.mul    = 1'b1;
          state_next = S_ADD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_ADD: begin
        cmd.add    = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag       = 1'b1;
        step_cnt_next = '0;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.step      = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_W'(DIV_STEPS - 1)) state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step_cnt <= '0;
    end else begin
      state    <= state_next;
      step_cnt <= step_cnt_next;
    end
  end

endmodule

// File: rtl/rms_dpath.sv
// ----------------------------------------------------------------------------
// rms_dpath
// Config registers, match, multiplier, carry add, restoring divider, output.
// ----------------------------------------------------------------------------
module rms_dpath import rms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [7:0]           event_type,
  input  logic [15:0]          event_code,
  input  logic [31:0]          event_value,
  input  ctrl_cmd_t            cmd,
  output ctrl_stat_t           stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_value,
  output logic                 was_scaled
);

  logic [7:0]  match_type;
  logic [2:0]  code_count;
  logic [15:0] code_reg [CODE_REGS];
  logic [31:0] numerator, denominator;
  logic [15:0] carry_x, carry_y;

  logic        hit, sel_x, sel_y;
  logic [31:0] val, prod, sum, mb, rem, quo;
  logic        na, nb;

  logic [2:0]          limit;
  logic                hit_now;
  logic [31:0]         num_eff, den_eff, carry_ext, q_signed, r_signed;
  logic [32:0]         shl, diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      match_type  <= 8'd2;
      code_count  <= 3'd2;
      code_reg[0] <= 16'd0;
      code_reg[1] <= 16'd1;
      code_reg[2] <= 16'd0;
      code_reg[3] <= 16'd0;
      numerator   <= 32'd1;
      denominator <= 32'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MATCH_TYPE:  match_type  <= cfg_data[7:0];
        REG_CODE_COUNT:  code_count  <= cfg_data[2:0];
        REG_CODE_0:      code_reg[0] <= cfg_data[15:0];
        REG_CODE_1:      code_reg[1] <= cfg_data[15:0];
        REG_CODE_2:      code_reg[2] <= cfg_data[15:0];
        REG_CODE_3:      code_reg[3] <= cfg_data[15:0];
        REG_NUMERATOR:   numerator   <= cfg_data;
        REG_DENOMINATOR: denominator <= cfg_data;
        default: ;
      endcase
    end
  end

  assign limit = (code_count > SLOT_LIMIT) ? SLOT_LIMIT : code_count;

  always_comb begin
    hit_now = 1'b0;
    for (int i = 0; i < CODE_REGS; i++) begin
      if ((3'(i) < limit) && (code_reg[i] == event_code)) hit_now = 1'b1;
    end
    hit_now = hit_now && (event_type == match_type);
  end

  assign num_eff   = (numerator == 32'd0) ? 32'd1 : numerator;
  assign den_eff   = (denominator == 32'd0) ? 32'd1 : denominator;
  assign carry_ext = sel_x ? sext16(carry_x) : (sel_y ? sext16(carry_y) : 32'd0);

  assign shl  = {rem, quo[31]};
  assign diff = shl - {1'b0, mb};

  assign q_signed = (na ^ nb) ? (32'd0 - quo) : quo;
  assign r_signed = na ? (32'd0 - rem) : rem;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val   <= event_value;
      hit   <= hit_now;
      sel_x <= (event_code == CODE_X);
      sel_y <= (event_code == CODE_Y);
    end
    if (cmd.mul) prod <= 32'(val * num_eff);
    if (cmd.add) sum <= prod + carry_ext;
    if (cmd.mag) begin
      na  <= sum[31];
      nb  <= den_eff[31];
      quo <= sum[31] ? (32'd0 - sum) : sum;
      mb  <= den_eff[31] ? (32'd0 - den_eff) : den_eff;
      rem <= '0;
    end
    if (cmd.step) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shl[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (cmd.fin) begin
      out_value  <= hit ? sext16(q_signed[15:0]) : val;
      was_scaled <= hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carry_x <= '0;
      carry_y <= '0;
    end else if (cmd.fin && hit) begin
      if (sel_x) carry_x <= r_signed[15:0];
      if (sel_y) carry_y <= r_signed[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.fin) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.hit      = hit;
  assign stat.out_free = !out_valid || out_ready;

endmodule

// File: rtl/ratio_motion_scaler_with_remainder_core.sv
// ----------------------------------------------------------------------------
// ratio_motion_scaler_with_remainder_core
// Scales matching motion events by numerator/denominator with per-axis
// remainder carry; other events pass through.
// ----------------------------------------------------------------------------
// Channel  Signals                                    Transfer
// in       in_valid in_ready event_type/code/value    valid & ready
// out      out_valid out_ready out_value was_scaled   valid & ready
// cfg      cfg_valid cfg_ready cfg_index cfg_data     valid & ready
//
// Scaled event: input transfer, then multiply, carry add, magnitude,
// 32 radix-2 divider steps and result write to the output register.
// Pass-through event: input transfer, then result write. One event in flight at a time.
// A finished result waits in the output register; the next event is taken
// meanwhile and stalls only at its own result write.
// Synchronous reset restores the register defaults and clears both carries.
// ----------------------------------------------------------------------------
module ratio_motion_scaler_with_remainder_core import rms_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           event_type,
  input  logic [15:0]          event_code,
  input  logic [31:0]          event_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_value,
  output logic                 was_scaled,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  rms_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rms_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .was_scaled  (was_scaled)
  );

endmodule

// File: rtl/rms_chk.sv
// ----------------------------------------------------------------------------
// rms_chk
// Port-level checks for the ratio motion scaler core.
// ----------------------------------------------------------------------------
module rms_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic        was_scaled
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(was_scaled))
    else $error("stalled result changed");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second event taken while one is in flight");

  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without an event in flight");

endmodule

bind ratio_motion_scaler_with_remainder_core rms_chk u_rms_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_value  (out_value),
  .was_scaled (was_scaled)
);

// File: sim/ratio_motion_scaler_with_remainder_core_tb.sv
// ----------------------------------------------------------------------------
// ratio_motion_scaler_with_remainder_core_tb
// Self-checking bench for the ratio motion scaler. Events and register writes
// go in over valid/ready channels; a scoreboard predicts each scaled or
// passed-through result, including the per-axis remainder carry, and checks
// every output transfer in order. Directed corner events come first, then
// randomized phases, all but the first under random idling; one adds long back-pressure.
// ----------------------------------------------------------------------------
module ratio_motion_scaler_with_remainder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rms_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [31:0] value;
    logic        scaled;
  } motion_result_t;

  typedef logic [31:0] reg_file_t [8];

  class motion_ratio_scoreboard;
    logic [7:0]     match_type;
    logic [2:0]     code_count;
    logic [15:0]    codes [CODE_REGS];
    logic [31:0]    num_reg;
    logic [31:0]    den_reg;
    logic [15:0]    carry_x;
    logic [15:0]    carry_y;
    motion_result_t expected_motion [$];
    int             mismatches;

    function new();
      match_type = 8'd2;
      code_count = 3'd2;
      codes[0]   = 16'd0;
      codes[1]   = 16'd1;
      codes[2]   = 16'd0;
      codes[3]   = 16'd0;
      num_reg    = 32'd1;
      den_reg    = 32'd1;
      carry_x    = '0;
      carry_y    = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        REG_MATCH_TYPE:  match_type = data[7:0];
        REG_CODE_COUNT:  code_count = data[2:0];
        REG_CODE_0:      codes[0]   = data[15:0];
        REG_CODE_1:      codes[1]   = data[15:0];
        REG_CODE_2:      codes[2]   = data[15:0];
        REG_CODE_3:      codes[3]   = data[15:0];
        REG_NUMERATOR:   num_reg    = data;
        REG_DENOMINATOR: den_reg    = data;
        default: ;
      endcase
    endfunction

    // signed divide truncating toward zero; -2^31 / -1 wraps
    function logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma;
      logic [31:0] mb;
      logic [31:0] q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q  = ma / mb;
      return (a[31] != b[31]) ? -q : q;
    endfunction

    function void note_event(logic [7:0] ev_type, logic [15:0] ev_code,
                             logic [31:0] ev_value);
      int             slots;
      bit             hit;
      logic [31:0]    n;
      logic [31:0]    d;
      logic [31:0]    prod;
      logic [31:0]    q;
      logic [31:0]    rem;
      motion_result_t res;
      slots = (code_count > MAX_CODES) ? MAX_CODES : code_count;
      if (slots > CODE_REGS) slots = CODE_REGS;
      hit = 0;
      if (ev_type == match_type)
        for (int i = 0; i < slots; i++)
          if (codes[i] == ev_code) hit = 1;
      if (!hit) begin
        res.value  = ev_value;
        res.scaled = 1'b0;
      end else begin
        n    = (num_reg == 0) ? 32'd1 : num_reg;
        d    = (den_reg == 0) ? 32'd1 : den_reg;
        prod = ev_value * n;
        if (ev_code == CODE_X) prod = prod + {{16{carry_x[15]}}, carry_x};
        else if (ev_code == CODE_Y) prod = prod + {{16{carry_y[15]}}, carry_y};
        q   = div_toward_zero(prod, d);
        rem = prod - q * d;
        if (ev_code == CODE_X) carry_x = rem[15:0];
        else if (ev_code == CODE_Y) carry_y = rem[15:0];
        res.value  = {{16{q[15]}}, q[15:0]};
        res.scaled = 1'b1;
      end
      expected_motion.push_back(res);
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
      mismatches++;
      if (mismatches <= 10) $display("%s: expected %h, got %h", what, exp_v, got_v);
    endfunction

    function void check_result(logic [31:0] got_value, logic got_scaled);
      motion_result_t exp_r;
      if (expected_motion.size() == 0) begin
        flag("result with nothing pending, out_value", 32'h0, got_value);
        return;
      end
      exp_r = expected_motion.pop_front();
      if (got_value !== exp_r.value) flag("out_value", exp_r.value, got_value);
      if (got_scaled !== exp_r.scaled) flag("was_scaled", 32'(exp_r.scaled), 32'(got_scaled));
    endfunction
  endclass

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic [7:0]           event_type  = '0;
  logic [15:0]          event_code  = '0;
  logic [31:0]          event_value = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  logic [31:0]          out_value;
  logic                 was_scaled;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [31:0]          cfg_data    = '0;

  bit calm     = 1'b0;
  bit hold_req = 1'b0;

  motion_ratio_scoreboard sb = new();

  ratio_motion_scaler_with_remainder_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .was_scaled  (was_scaled),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  // result side: checks transfers, drives out_ready, serves hold-off requests
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) sb.check_result(out_value, was_scaled);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !rst && (calm || ($urandom_range(99) >= 17));
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("ratio_motion_scaler_with_remainder_core: mismatch");
        $finish;
      end
    end
  end

  task automatic send_event(logic [7:0] t, logic [15:0] c, logic [31:0] v);
    int gap;
    gap = 0;
    while (!calm && $urandom_range(99) < 17) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    event_type  <= t;
    event_code  <= c;
    event_value <= v;
    in_valid    <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_event(t, c, v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_motion.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_setting(reg_file_t s);
    drain();
    for (int i = 0; i < $size(s); i++) begin
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= s[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(CFG_IDX_W'(i), s[i]);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_ratio_term();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      3:       return $urandom;
      4:       return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(40)) - 32'd20;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(19))
      0:             return 32'h8000_0000;
      1:             return 32'h7FFF_FFFF;
      2:             return 32'hFFFF_FFFF;
      3, 4, 5, 6:    return $urandom;
      7, 8, 9:       return 32'($urandom_range(400000)) - 32'd200000;
      default:       return 32'($urandom_range(4000)) - 32'd2000;
    endcase
  endfunction

  task automatic random_phase(int n_items, bit do_hold);
    reg_file_t   s;
    logic [7:0]  t;
    logic [15:0] c;
    int          r;
    s[REG_MATCH_TYPE] = ($urandom_range(3) == 0) ? 32'($urandom_range(255)) : 32'd2;
    s[REG_CODE_COUNT] = ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(2, 4));
    for (int i = 0; i < CODE_REGS; i++) begin
      r = $urandom_range(5);
      s[REG_CODE_0 + i] = (r == 0) ? $urandom :
                          (r < 3)  ? {16'($urandom), CODE_X} : {16'($urandom), CODE_Y};
    end
    s[REG_NUMERATOR]   = pick_ratio_term();
    s[REG_DENOMINATOR] = pick_ratio_term();
    load_setting(s);
    for (int k = 0; k < n_items; k++) begin
      if (do_hold && k == 8) hold_req = 1'b1;
      r = $urandom_range(99);
      t = (r < 75) ? s[REG_MATCH_TYPE][7:0] :
          (r < 90) ? 8'($urandom_range(255)) : ~s[REG_MATCH_TYPE][7:0];
      r = $urandom_range(99);
      c = (r < 60) ? s[REG_CODE_0 + $urandom_range(3)][15:0] :
          (r < 73) ? CODE_X :
          (r < 86) ? CODE_Y : 16'($urandom_range(65535));
      send_event(t, c, pick_value());
    end
  endtask

  initial begin
    reg_file_t s;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // power-on registers: X/Y of type 2 at ratio 1
    send_event(8'd2, CODE_X, 32'd5);
    send_event(8'd2, CODE_Y, 32'hFFFF_FFF9);
    send_event(8'd2, 16'd5, 32'd77);
    send_event(8'd3, CODE_X, 32'h7FFF_FFFF);
    send_event(8'd2, CODE_Y, 32'h8000_0000);

    // 3/7 with carry build-up, all four slots
    s[REG_MATCH_TYPE]  = 32'd2;
    s[REG_CODE_COUNT]  = 32'd4;
    s[REG_CODE_0]      = 32'h0000_0000;
    s[REG_CODE_1]      = 32'h0000_0001;
    s[REG_CODE_2]      = 32'h0000_1234;
    s[REG_CODE_3]      = 32'h0000_FFFF;
    s[REG_NUMERATOR]   = 32'd3;
    s[REG_DENOMINATOR] = 32'd7;
    load_setting(s);
    send_event(8'd2, CODE_X, 32'd1);
    send_event(8'd2, CODE_X, 32'd1);
    send_event(8'd2, CODE_X, 32'd1);
    send_event(8'd2, CODE_Y, 32'hFFFF_FFFF);
    send_event(8'd2, CODE_Y, 32'hFFFF_FFFF);
    send_event(8'd2, 16'h1234, 32'd100);
    send_event(8'd2, 16'hFFFF, 32'hFFFF_FF9C);
    send_event(8'hFF, CODE_X, 32'd5);
    send_event(8'd2, CODE_X, 32'h7FFF_FFFF);

    // zero ratio terms read as one, oversized count, 16-bit wrap of quotient
    s[REG_MATCH_TYPE]  = 32'h0000_00FF;
    s[REG_CODE_COUNT]  = 32'd7;
    s[REG_CODE_0]      = 32'h0000_FFFF;
    s[REG_CODE_1]      = 32'h0000_0000;
    s[REG_CODE_2]      = 32'h0000_0001;
    s[REG_CODE_3]      = 32'h0000_00AA;
    s[REG_NUMERATOR]   = 32'h0000_0000;
    s[REG_DENOMINATOR] = 32'h0000_0000;
    load_setting(s);
    send_event(8'hFF, 16'hFFFF, 32'h1234_5678);
    send_event(8'hFF, 16'h00AA, 32'hFFFF_FFFD);
    send_event(8'hFF, CODE_X, 32'd40000);

    // -2^31 / -1 wrap, with and without carry; count of two
    s[REG_MATCH_TYPE]  = 32'd0;
    s[REG_CODE_COUNT]  = 32'd2;
    s[REG_CODE_0]      = 32'h0000_8000;
    s[REG_CODE_1]      = 32'h0000_0000;
    s[REG_CODE_2]      = 32'h0000_0001;
    s[REG_CODE_3]      = 32'h0000_0002;
    s[REG_NUMERATOR]   = 32'd1;
    s[REG_DENOMINATOR] = 32'hFFFF_FFFF;
    load_setting(s);
    send_event(8'd0, 16'h8000, 32'h8000_0000);
    send_event(8'd0, CODE_X, 32'h8000_0000);
    send_event(8'd0, CODE_Y, 32'd9);

    // no active slots: everything passes; extreme ratio terms
    s[REG_CODE_COUNT]  = 32'd0;
    s[REG_NUMERATOR]   = 32'h8000_0000;
    s[REG_DENOMINATOR] = 32'h7FFF_FFFF;
    load_setting(s);
    send_event(8'd0, CODE_X, 32'd123);
    send_event(8'd0, 16'h8000, 32'hDEAD_BEEF);

    calm = 1'b1;
    random_phase(55, 1'b0);
    calm = 1'b0;
    random_phase(55, 1'b0);
    random_phase(55, 1'b1);
    random_phase(55, 1'b0);
    random_phase(55, 1'b0);
    random_phase(55, 1'b0);
    random_phase(55, 1'b0);

    drain();
    if (sb.mismatches == 0 && sb.expected_motion.size() == 0)
      $display("ratio_motion_scaler_with_remainder_core: match");
    else
      $display("ratio_motion_scaler_with_remainder_core: mismatch");
    $finish;
  end

endmodule
